// ----- rtl/core/bdpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bdpc_pkg
// types and constants shared by the button debounce and press classifier
// ----------------------------------------------------------------------------
`default_nettype none

package bdpc_pkg;

  localparam int unsigned DebWidth    = 10;
  localparam int unsigned HoldWidth   = 16;
  localparam int unsigned StableWidth = 11;
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned TdataWidth  = 8;

  localparam logic [DebWidth-1:0]    DebTicksRst  = DebWidth'(20);
  localparam logic [HoldWidth-1:0]   HoldTicksRst = HoldWidth'(1000);
  localparam logic [StableWidth-1:0] StableMax    = '1;
  localparam logic [HoldWidth-1:0]   HoldMax      = '1;

  localparam logic [CfgIdxWidth-1:0] RegDebounceTicks = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegLongHoldTicks = 1'b1;

  typedef struct packed {
    logic                   prev_raw;
    logic                   deb_level;
    logic [StableWidth-1:0] stable_cnt;
    logic [HoldWidth-1:0]   hold_cnt;
    logic                   long_seen;
  } state_t;

  typedef struct packed {
    logic [DebWidth-1:0]  deb_ticks;
    logic [HoldWidth-1:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic long_press;
    logic short_press;
    logic debounced_pressed;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/bdpc_step.sv -----
// ----------------------------------------------------------------------------
// bdpc_step
// next-state and result logic for one tick of the button
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_step (
  input  bdpc_pkg::state_t  state_i,
  input  bdpc_pkg::cfg_t    cfg_i,
  input  logic              raw_pressed_i,
  output bdpc_pkg::state_t  state_o,
  output bdpc_pkg::result_t result_o
);
  import bdpc_pkg::*;

  logic [HoldWidth-1:0]   hold_inc;
  logic [StableWidth-1:0] stable_nxt;
  logic                   level_ok;
  logic                   press_edge;
  logic                   long_hit;

  always_comb begin
    if (state_i.deb_level && (state_i.hold_cnt != HoldMax)) begin
      hold_inc = state_i.hold_cnt + HoldWidth'(1);
    end else begin
      hold_inc = state_i.hold_cnt;
    end

    if (raw_pressed_i != state_i.prev_raw) begin
      stable_nxt = '0;
    end else if (state_i.stable_cnt != StableMax) begin
      stable_nxt = state_i.stable_cnt + StableWidth'(1);
    end else begin
      stable_nxt = state_i.stable_cnt;
    end

    level_ok   = stable_nxt > {1'b0, cfg_i.deb_ticks};
    press_edge = level_ok && !state_i.deb_level && raw_pressed_i;

    state_o            = state_i;
    state_o.prev_raw   = raw_pressed_i;
    state_o.stable_cnt = stable_nxt;
    state_o.hold_cnt   = press_edge ? '0 : hold_inc;
    state_o.long_seen  = press_edge ? 1'b0 : state_i.long_seen;
    state_o.deb_level  = level_ok ? raw_pressed_i : state_i.deb_level;

    result_o.short_press = level_ok && state_i.deb_level && !raw_pressed_i
                           && !state_i.long_seen;

    long_hit = state_o.deb_level && !state_o.long_seen
               && (state_o.hold_cnt >= cfg_i.hold_ticks);
    state_o.long_seen = state_o.long_seen | long_hit;

    result_o.long_press        = long_hit;
    result_o.debounced_pressed = state_o.deb_level;
  end

endmodule

`default_nettype wire

// ----- rtl/core/button_debounce_press_classifier.sv -----
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// debounces one push button and flags short and long presses per tick
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         tdata[0] raw_pressed
//  m_axis    out        tdata[0] debounced_pressed, [1] short_press, [2] long_press
//  cfg       in         idx 0 debounce_ticks, idx 1 long_hold_ticks
//
//  one request per cycle sustained while m_axis_tready does not stall the output
//  the tick is processed as it moves from the input register to the result register
//  reset clears the button state and loads debounce 20, long hold 1000
//  a stalled output holds the result while the input register takes one more request
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_press_classifier (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bdpc_pkg::TdataWidth-1:0]   s_axis_tdata,   // raw_pressed
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bdpc_pkg::TdataWidth-1:0]   m_axis_tdata,   // debounced_pressed, short, long
  input  logic                              cfg_we_i,
  input  logic [bdpc_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [bdpc_pkg::CfgWidth-1:0]     cfg_data_i
);
  import bdpc_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t res_d, res_q;
  logic    in_vld_q;
  logic    in_raw_q;
  logic    out_vld_q;
  logic    advance;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  bdpc_step u_step (
    .state_i       (state_q),
    .cfg_i         (cfg_q),
    .raw_pressed_i (in_raw_q),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deb_ticks  <= DebTicksRst;
      cfg_q.hold_ticks <= HoldTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDebounceTicks: cfg_q.deb_ticks  <= cfg_data_i[DebWidth-1:0];
        RegLongHoldTicks: cfg_q.hold_ticks <= cfg_data_i[HoldWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_raw_q <= s_axis_tdata[0];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(TdataWidth-3){1'b0}},
                          res_q.long_press, res_q.short_press, res_q.debounced_pressed};

endmodule

`default_nettype wire

// ----- tb/tb_button_debounce_press_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_press_classifier
// self-checking bench for the button debouncer and press classifier
// ----------------------------------------------------------------------------
// a short directed table with hand-read results comes first: reset levels,
// zero debounce and zero hold time, one short and one long press. then one
// press at the largest hold time with spare debounce bits set, which stays short.
// then random phases of bounced presses, glitches and noise under random
// settings. every request outside the table is scored by an in-bench model of the classifier;
// both stream sides idle in random bursts, and not at all near the end
// ----------------------------------------------------------------------------

module tb_button_debounce_press_classifier;

  import bdpc_pkg::*;

  localparam int unsigned CycleLimit = 10_000_000;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CfgIdxWidth-1:0] idx;
    logic [CfgWidth-1:0]    data;
    logic                   typed;
    result_t                exp;
  } row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TdataWidth-1:0]  s_axis_tdata = '0;   // [0] raw_pressed
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TdataWidth-1:0]  m_axis_tdata;        // [0] debounced_pressed, [1] short, [2] long
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [CfgWidth-1:0]    cfg_data_i = '0;

  // model state and settings
  logic                   btn_prev = 1'b0;
  logic                   btn_level = 1'b0;
  logic [StableWidth-1:0] stable_ticks = '0;
  logic [HoldWidth-1:0]   held_ticks = '0;
  logic                   long_flag = 1'b0;
  logic [DebWidth-1:0]    cfg_debounce = DebTicksRst;
  logic [HoldWidth-1:0]   cfg_long_hold = HoldTicksRst;

  result_t     button_results_q[$];
  logic        cur_typed = 1'b0;
  result_t     cur_exp = '0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  bit          quiet = 1'b0;
  int unsigned tick_count = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  row_t directed_rows [22] = '{
    // reset settings: nothing is accepted yet
    '{ROW_TICK, RegDebounceTicks, 16'd0, 1'b1, 3'b000},
    '{ROW_TICK, RegDebounceTicks, 16'd1, 1'b1, 3'b000},
    '{ROW_TICK, RegDebounceTicks, 16'd1, 1'b1, 3'b000},
    '{ROW_TICK, RegDebounceTicks, 16'd0, 1'b1, 3'b000},
    // no debounce, zero hold time: long press on the accepting tick
    '{ROW_CFG,  RegDebounceTicks, 16'd0, 1'b0, 3'b000},
    '{ROW_CFG,  RegLongHoldTicks, 16'd0, 1'b0, 3'b000},
    '{ROW_TICK, RegDebounceTicks, 16'd1, 1'b1, 3'b000},
    '{ROW_TICK, RegDebounceTicks, 16'd1, 1'b1, 3'b101},
    '{ROW_TICK, RegDebounceTicks, 16'd1, 1'b1, 3'b001},
    '{ROW_TICK, RegDebounceTicks, 16'd0, 1'b1, 3'b001},
    '{ROW_TICK, RegDebounceTicks, 16'd0, 1'b1, 3'b000},
    // hold time of two: a short press, then a long one
    '{ROW_CFG,  RegLongHoldTicks, 16'd2, 1'b0, 3'b000},
    '{ROW_TICK, RegDebounceTicks, 16'd1, 1'b1, 3'b000},
    '{ROW_TICK, RegDebounceTicks, 16'd1, 1'b1, 3'b001},
    '{ROW_TICK, RegDebounceTicks, 16'd0, 1'b1, 3'b001},
    '{ROW_TICK, RegDebounceTicks, 16'd0, 1'b1, 3'b010},
    '{ROW_TICK, RegDebounceTicks, 16'd1, 1'b1, 3'b000},
    '{ROW_TICK, RegDebounceTicks, 16'd1, 1'b1, 3'b001},
    '{ROW_TICK, RegDebounceTicks, 16'd1, 1'b1, 3'b001},
    '{ROW_TICK, RegDebounceTicks, 16'd1, 1'b1, 3'b101},
    '{ROW_TICK, RegDebounceTicks, 16'd0, 1'b1, 3'b001},
    '{ROW_TICK, RegDebounceTicks, 16'd0, 1'b1, 3'b000}
  };

  button_debounce_press_classifier DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever begin
      #4 clk_i = ~clk_i;
    end
  end

  function automatic result_t classify_tick(input logic raw);
    result_t res;
    res = '0;
    if (btn_level && held_ticks != HoldMax) begin
      held_ticks = held_ticks + 1'b1;
    end
    if (raw != btn_prev) begin
      stable_ticks = '0;
    end else if (stable_ticks != StableMax) begin
      stable_ticks = stable_ticks + 1'b1;
    end
    btn_prev = raw;
    if (stable_ticks > StableWidth'(cfg_debounce)) begin
      if (!btn_level && raw) begin
        held_ticks = '0;
        long_flag  = 1'b0;
      end
      if (btn_level && !raw && !long_flag) begin
        res.short_press = 1'b1;
      end
      btn_level = raw;
    end
    if (btn_level && !long_flag && held_ticks >= cfg_long_hold) begin
      long_flag      = 1'b1;
      res.long_press = 1'b1;
    end
    res.debounced_pressed = btn_level;
    return res;
  endfunction

  function automatic void check_bit(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = classify_tick(s_axis_tdata[0]);
        button_results_q.push_back(cur_typed ? cur_exp : want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[2:0]);
        if (button_results_q.size() == 0) begin
          $error("unexpected result %03b", got);
          error_count++;
        end else begin
          want = button_results_q.pop_front();
          check_bit("debounced_pressed", want.debounced_pressed, got.debounced_pressed);
          check_bit("short_press", want.short_press, got.short_press);
          check_bit("long_press", want.long_press, got.long_press);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input logic raw, input logic typed, input result_t exp);
    int unsigned gap;
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk_i);
    cur_typed = typed;
    cur_exp   = exp;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TdataWidth'(raw);
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
    tick_count++;
  endtask

  task automatic send_run(input logic level, input int unsigned n);
    repeat (n) send_tick(level, 1'b0, '0);
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_tick(1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (button_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgWidth-1:0] data);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == RegDebounceTicks) begin
      cfg_debounce = data[DebWidth-1:0];
    end else if (idx == RegLongHoldTicks) begin
      cfg_long_hold = data[HoldWidth-1:0];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // bounced press and release, a glitch too short to accept, or plain noise
  task automatic press_cycle();
    int unsigned pick;
    int unsigned deb;
    int unsigned hold_len;
    pick = $urandom_range(0, 9);
    deb  = int'(cfg_debounce);
    if (pick < 7) begin
      hold_len = $urandom_range(0, 2 * int'(cfg_long_hold) + 3);
      send_noise($urandom_range(0, 4));
      send_run(1'b1, deb + 2 + hold_len);
      send_noise($urandom_range(0, 4));
      send_run(1'b0, deb + 2 + $urandom_range(0, 4));
    end else if (pick < 9) begin
      send_run(1'b1, $urandom_range(1, deb + 1));
      send_run(1'b0, $urandom_range(1, deb + 1));
    end else begin
      send_noise($urandom_range(1, 12));
    end
  endtask

  initial begin
    int unsigned rand_base;
    int unsigned deb_pick;
    int unsigned hold_pick;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_tick(directed_rows[i].data[0], directed_rows[i].typed, directed_rows[i].exp);
      end
    end

    // largest hold time, spare debounce bits set; the press ends short
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    write_reg(RegDebounceTicks, 16'hFC03);
    write_reg(RegLongHoldTicks, '1);
    send_run(1'b1, 30);
    send_run(1'b0, 10);

    rand_base = tick_count;
    while (tick_count - rand_base < 1050) begin
      quiet = (tick_count - rand_base >= 850);
      deb_pick  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
      hold_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
      write_reg(RegDebounceTicks, CfgWidth'(($urandom_range(0, 63) << DebWidth) | deb_pick));
      write_reg(RegLongHoldTicks, CfgWidth'(hold_pick));
      repeat (4) begin
        tx_idle_on = !quiet && $urandom_range(0, 2) != 0;
        rx_idle_on = !quiet && $urandom_range(0, 2) != 0;
        press_cycle();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
